// ===== src/signed_int_to_radix_symbols_macros.svh =====
// ---------------------------------------------------------------------------
// signed_int_to_radix_symbols assertion macros
// Shared concurrent assertion forms for the radix symbol converter.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_SYMBOLS_MACROS_SVH
`define SIGNED_INT_TO_RADIX_SYMBOLS_MACROS_SVH

// Condition must never hold while out of reset.
`define SIRS_ASSERT_NEVER(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("sirs: forbidden condition seen");

// Antecedent in a cycle requires the consequent in the same cycle.
`define SIRS_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sirs: implication violated");

`endif

// ===== src/sirs_pkg.sv =====
// ---------------------------------------------------------------------------
// sirs_pkg
// Widths, depths, opcodes and character codes of the radix symbol converter.
// ---------------------------------------------------------------------------
`default_nettype none

package sirs_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int MAX_SYMBOLS = 128;

  localparam int SYM_W       = 7;
  localparam int TABLE_DEPTH = 128;
  localparam int TABLE_AW    = 7;
  localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);
  localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
  localparam int DIGIT_DEPTH = NUMBER_BITS;
  localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
  localparam int NDIG_W      = $clog2(DIGIT_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(NUMBER_BITS);

  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_CONVERT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [7:0] SYM_LOW    = 8'd32;
  localparam logic [7:0] SYM_HIGH   = 8'd126;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic                   done;
    logic [NUMBER_BITS-1:0] quot;
    logic [DIGIT_W-1:0]     rem;
  } div_result_t;

endpackage

`default_nettype wire

// ===== src/sirs_div.sv =====
// ---------------------------------------------------------------------------
// sirs_div
// Restoring divider, one quotient bit per cycle, for digit extraction.
// ---------------------------------------------------------------------------
`default_nettype none

module sirs_div
  import sirs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [NUMBER_BITS-1:0] dividend,
  input  wire logic [COUNT_W-1:0]     divisor,
  output div_result_t                 res
);

  logic                   busy;
  logic                   done;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [NUMBER_BITS-1:0] quot;
  logic [COUNT_W-1:0]     rem;
  logic [COUNT_W-1:0]     dvs;
  logic [COUNT_W:0]       trial;
  logic [COUNT_W:0]       diff;
  logic                   take;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem, quot[NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUMBER_BITS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[NUMBER_BITS-2:0], take};
      rem  <= take ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ===== src/signed_int_to_radix_symbols.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_radix_symbols
// Builds a digit alphabet and spells signed numbers in its radix.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the opcode (append, convert, clear), tdata
//   carries the symbol byte and the 32-bit signed number. A convert against an
//   alphabet that is marked bad or has fewer than two symbols yields no word.
//   Master stream: one word per character, a minus sign for negative values,
//   then the digits most significant first; tlast marks the final digit.
//   A convert runs one division per digit on a shared restoring divider,
//   then reads each character back through the digit store and the symbol
//   table memory.
//   Items are taken one at a time; the slave side waits until the last
//   character of a conversion sits in the output register. A stalled master
//   holds that register and pauses character emission, nothing is dropped.
//   Reset empties the alphabet at once (the seen bits are flip-flops); the
//   symbol table memory is not cleared, only entries below the count are read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_radix_symbols_macros.svh"

module signed_int_to_radix_symbols
  import sirs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [7:0] symbol, [39:8] number
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] character
  output logic             m_tlast
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DIV_START = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
  localparam logic [2:0] ST_SIGN      = 3'd3;
  localparam logic [2:0] ST_RD_DIGIT  = 3'd4;
  localparam logic [2:0] ST_RD_SYM    = 3'd5;
  localparam logic [2:0] ST_OUT       = 3'd6;

  logic [2:0]             state;

  // Alphabet state
  logic [SYM_W-1:0]       symbol_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] seen;
  logic [COUNT_W-1:0]     count;
  logic                   bad;

  // Conversion state
  logic [DIGIT_W-1:0]     digit_mem [DIGIT_DEPTH];
  logic [NUMBER_BITS-1:0] mag;
  logic                   neg;
  logic [NDIG_W-1:0]      ndig;
  logic [DIGIT_AW-1:0]    idx;
  logic [DIGIT_W-1:0]     dig_q;
  logic [SYM_W-1:0]       sym_q;

  // Input unpacking
  logic                   in_fire;
  logic [1:0]             opcode;
  logic [7:0]             symbol;
  logic [NUMBER_BITS-1:0] num_u;
  logic                   num_neg;
  logic                   sym_bad;
  logic                   append_ok;
  logic                   out_free;
  logic                   out_load;
  logic                   div_start;
  div_result_t            div_res;

  assign opcode  = s_tuser;
  assign symbol  = s_tdata[7:0];
  assign num_u   = s_tdata[8 +: NUMBER_BITS];
  assign num_neg = num_u[NUMBER_BITS-1];

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  // Load the output register with a sign or a digit character.
  assign out_load  = out_free && (state == ST_SIGN || state == ST_OUT);
  assign div_start = (state == ST_DIV_START);

  // Reject out-of-range, sign characters and repeats; a full table fails too.
  assign sym_bad   = (symbol < SYM_LOW) || (symbol > SYM_HIGH) ||
                     (symbol == CHAR_PLUS) || (symbol == CHAR_MINUS) ||
                     seen[symbol[SYM_W-1:0]];
  assign append_ok = (count < COUNT_W'(MAX_SYMBOLS)) && !sym_bad;

  sirs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (count),
    .res      (div_res)
  );

  // Symbol table: written on a good append, read at the current digit.
  always_ff @(posedge clk) begin
    if (in_fire && opcode == OP_APPEND && append_ok) begin
      symbol_mem[count[TABLE_AW-1:0]] <= symbol[SYM_W-1:0];
    end
    sym_q <= symbol_mem[dig_q];
  end

  // Digit store: filled least significant first, read back in reverse.
  always_ff @(posedge clk) begin
    if (state == ST_DIV_WAIT && div_res.done) begin
      digit_mem[ndig[DIGIT_AW-1:0]] <= div_res.rem;
    end
    dig_q <= digit_mem[idx];
  end

  // Alphabet control
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      count <= '0;
      bad   <= 1'b0;
    end else if (in_fire) begin
      case (opcode)
        OP_APPEND: begin
          if (append_ok) begin
            seen[symbol[SYM_W-1:0]] <= 1'b1;
            count                   <= count + 1'b1;
          end else begin
            bad <= 1'b1;
          end
        end
        OP_CLEAR: begin
          seen  <= '0;
          count <= '0;
          bad   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Hold the word until taken; drop valid once it leaves.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && opcode == OP_CONVERT && !bad && count >= COUNT_W'(2)) begin
            state <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_res.done) begin
            if (div_res.quot == '0) begin
              state <= neg ? ST_SIGN : ST_RD_DIGIT;
            end else begin
              state <= ST_DIV_START;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            state <= ST_RD_DIGIT;
          end
        end
        ST_RD_DIGIT: begin
          state <= ST_RD_SYM;
        end
        ST_RD_SYM: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= (idx == '0) ? ST_IDLE : ST_RD_DIGIT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Conversion payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      // Two's complement negate also maps the most negative value correctly.
      mag  <= num_neg ? (~num_u + 1'b1) : num_u;
      neg  <= num_neg;
      ndig <= '0;
    end
    if (state == ST_DIV_WAIT && div_res.done) begin
      mag  <= div_res.quot;
      ndig <= ndig + 1'b1;
      idx  <= ndig[DIGIT_AW-1:0];
    end
    if (state == ST_SIGN && out_free) begin
      m_tdata <= CHAR_MINUS;
      m_tlast <= 1'b0;
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= {1'b0, sym_q};
      m_tlast <= (idx == '0);
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

  // Checks
  `SIRS_ASSERT_NEVER(a_count_range, clk, rst, count > COUNT_W'(MAX_SYMBOLS))
  `SIRS_ASSERT_IMPLY(a_minus_not_last, clk, rst, m_tvalid && m_tdata == CHAR_MINUS, !m_tlast)
  `SIRS_ASSERT_IMPLY(a_div_done_waits, clk, rst, div_res.done, state == ST_DIV_WAIT)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: signed_int_to_radix_symbols testbench
// Builds symbol alphabets over the slave stream and spells numbers in their
// radix. A scoreboard predicts every character word and checks the master
// stream word by word, with random bursts, gaps and output stalls.
// ---------------------------------------------------------------------------

module tb;
  import sirs_pkg::*;

  // Opcode that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Input items in the random part.
  localparam int RANDOM_ITEMS = 220;
  // Longest convert is one division per digit plus character readback.
  localparam int DRAIN_CYCLES = 1200;
  // Output hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 4000;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } char_word_t;

  // -------------------------------------------------------------------------
  // Scoreboard: keeps its own alphabet and queues the characters each
  // convert must produce.
  // -------------------------------------------------------------------------
  class radix_scoreboard;
    logic [6:0]  glyph_table [TABLE_DEPTH];
    bit          glyph_seen [TABLE_DEPTH];
    int unsigned glyph_count;
    bit          alphabet_invalid;
    char_word_t  char_expect [$];
    int          errors;

    function new();
      forget_alphabet();
      errors = 0;
    endfunction

    function void forget_alphabet();
      foreach (glyph_seen[i]) glyph_seen[i] = 1'b0;
      glyph_count      = 0;
      alphabet_invalid = 1'b0;
    endfunction

    function void add_glyph(logic [7:0] sym);
      if (glyph_count >= MAX_SYMBOLS) begin
        alphabet_invalid = 1'b1;
      end else if (sym < SYM_LOW || sym > SYM_HIGH || sym == CHAR_PLUS ||
                   sym == CHAR_MINUS) begin
        alphabet_invalid = 1'b1;
      end else if (glyph_seen[sym[6:0]]) begin
        alphabet_invalid = 1'b1;
      end else begin
        glyph_seen[sym[6:0]]     = 1'b1;
        glyph_table[glyph_count] = sym[6:0];
        glyph_count++;
      end
    endfunction

    // Spell the number: minus sign first, then digits most significant first.
    function void spell_number(logic [NUMBER_BITS-1:0] num);
      logic [NUMBER_BITS-1:0] mag;
      int unsigned            digits [$];
      char_word_t             w;
      if (alphabet_invalid || glyph_count < 2) return;
      // Two's complement negate also covers the most negative value exactly.
      mag = num[NUMBER_BITS-1] ? -num : num;
      do begin
        digits.push_back(mag % glyph_count);
        mag = mag / glyph_count;
      end while (mag != 0);
      if (num[NUMBER_BITS-1]) begin
        w.character = CHAR_MINUS;
        w.last      = 1'b0;
        char_expect.push_back(w);
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
        w.character = {1'b0, glyph_table[digits[k]]};
        w.last      = (k == 0);
        char_expect.push_back(w);
      end
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] sym, logic [31:0] num);
      case (op)
        OP_APPEND:  add_glyph(sym);
        OP_CONVERT: spell_number(num[NUMBER_BITS-1:0]);
        OP_CLEAR:   forget_alphabet();
        default:    ;
      endcase
    endfunction

    task report_mismatch(string what);
      if (errors < 50) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_word(logic [7:0] character, logic last);
      char_word_t want;
      if (char_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%h last=%b", character, last));
        return;
      end
      want = char_expect.pop_front();
      if (character !== want.character)
        report_mismatch($sformatf("char got %h want %h", character, want.character));
      if (last !== want.last)
        report_mismatch($sformatf("last got %b want %b (char %h)", last, want.last,
                                  want.character));
    endtask

    function int pending();
      return char_expect.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and the block
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] symbol, [39:8] number
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] character
  logic        m_tlast;

  radix_scoreboard board = new();
  int          items_taken = 0;
  int          burst_left = 0;
  logic [7:0]  glyph_pool [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  signed_int_to_radix_symbols dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // -------------------------------------------------------------------------
  // Slave side: offer one word, hold it until taken, then pace the burst.
  // -------------------------------------------------------------------------
  task automatic offer_word(input logic [1:0] op, input logic [7:0] sym,
                            input logic [31:0] num);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {num, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(op, sym, num);
    if (op != OP_UNUSED) items_taken++;
    // Inside a burst keep tvalid high; between bursts drop it for a random gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 7);
    end
  endtask

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 1000);
      5:       return -$urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Symbols the alphabet must reject.
  function automatic logic [7:0] pick_bad_symbol();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 31));
      1:       return 8'($urandom_range(127, 255));
      2:       return CHAR_PLUS;
      default: return CHAR_MINUS;
    endcase
  endfunction

  // Mostly small alphabets (long digit strings), now and then wide ones.
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(2, 6);
    if (roll < 9) return $urandom_range(7, 20);
    return $urandom_range(21, glyph_pool.size());
  endfunction

  // Usually clear, then build a shuffled alphabet and convert a handful of numbers.
  // Sprinkle in bad symbols, repeats and random noise words.
  task automatic run_sequence(input int size);
    int         bad_at;
    int         converts;
    int         j;
    logic [7:0] tmp;
    if ($urandom_range(0, 9) != 0) offer_word(OP_CLEAR, 8'($urandom), $urandom);
    for (int i = glyph_pool.size() - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      tmp           = glyph_pool[i];
      glyph_pool[i] = glyph_pool[j];
      glyph_pool[j] = tmp;
    end
    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size) : -1;
    for (int i = 0; i <= size; i++) begin
      if (i == bad_at) offer_word(OP_APPEND, pick_bad_symbol(), $urandom);
      if (i < size) offer_word(OP_APPEND, glyph_pool[i], $urandom);
    end
    if ($urandom_range(0, 19) == 0)
      offer_word(OP_APPEND, glyph_pool[$urandom_range(0, size - 1)], $urandom);
    converts = $urandom_range(2, 5);
    for (int i = 0; i < converts; i++) begin
      if ($urandom_range(0, 9) == 0)
        offer_word(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
      offer_word(OP_CONVERT, 8'($urandom), pick_number());
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int random_start;
    for (int c = SYM_LOW; c <= SYM_HIGH; c++)
      if (c != CHAR_PLUS && c != CHAR_MINUS) glyph_pool.push_back(c[7:0]);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty and single-symbol alphabets give nothing.
    offer_word(OP_CONVERT, 8'h00, 32'd0);
    offer_word(OP_APPEND, 8'h00, 32'hFFFF_FFFF);      // lowest byte, rejected
    offer_word(OP_CONVERT, 8'hFF, 32'd5);
    offer_word(OP_CLEAR, 8'h00, 32'd0);
    offer_word(OP_APPEND, 8'hFF, 32'd0);              // highest byte, rejected
    offer_word(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    offer_word(OP_APPEND, "0", 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'd1);             // radix one: no output
    // Binary: most negative gives the longest string.
    offer_word(OP_APPEND, "1", 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'h8000_0000);
    offer_word(OP_CONVERT, 8'h00, 32'h7FFF_FFFF);
    offer_word(OP_CONVERT, 8'h00, 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'hFFFF_FFFF);
    offer_word(OP_UNUSED, 8'hA5, 32'h5A5A_A5A5);      // ignored
    // Edges of the printable range are legal symbols.
    offer_word(OP_APPEND, SYM_HIGH, 32'd0);
    offer_word(OP_APPEND, SYM_LOW, 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'hFFFF_FFFE);
    // Repeat marks the alphabet bad; later appends keep it bad.
    offer_word(OP_APPEND, "0", 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'd7);
    offer_word(OP_APPEND, "a", 32'd0);
    offer_word(OP_APPEND, 8'd127, 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'd9);
    offer_word(OP_CLEAR, 8'h00, 32'd0);
    offer_word(OP_APPEND, CHAR_PLUS, 32'd0);
    offer_word(OP_CLEAR, 8'h00, 32'd0);
    offer_word(OP_APPEND, CHAR_MINUS, 32'd0);
    offer_word(OP_APPEND, 8'd31, 32'd0);
    offer_word(OP_CONVERT, 8'h00, 32'd3);

    // Random: start with the widest alphabet, then mixed sizes.
    random_start = items_taken;
    run_sequence(glyph_pool.size());
    while (items_taken - random_start < RANDOM_ITEMS) run_sequence(pick_size());
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Master side: stall on changing patterns, with one long hold-off.
  // -------------------------------------------------------------------------
  initial begin : drain_side
    int  mode;
    int  span;
    int  period;
    bit  held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && items_taken >= 30) begin
        // Hold off long enough that the block backs up and stalls its input.
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 6);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (c % period == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check every word the master side takes.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
  end

  // Safety net against a hung block.
  initial begin : watchdog
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
